@@ design/hjrb_pkg.sv @@
// Shared types and constants for the HID joystick report builder.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hjrb_pkg;

    // Button storage never exceeds 32 bits (four report bytes).
    localparam int HJRB_BTN_STORE_MAX   = 32;
    localparam int HJRB_MAX_BUTTONS_DEF = 32;

    // APB register map, one 32-bit word per register
    localparam int HJRB_ADDR_W = 5;
    localparam logic [2:0] REG_BUTTON_COUNT = 3'd0;
    localparam logic [2:0] REG_AXIS_ENABLE  = 3'd1;
    localparam logic [2:0] REG_AUTO_SEND    = 3'd2;
    localparam logic [2:0] REG_RPT_TAG      = 3'd3;
    localparam logic [2:0] REG_X_RANGE      = 3'd4;
    localparam logic [2:0] REG_Y_RANGE      = 3'd5;
    localparam logic [2:0] REG_Z_RANGE      = 3'd6;
    localparam logic [2:0] REG_RX_RANGE     = 3'd7;

    localparam logic [5:0]  RST_BUTTON_COUNT = 6'd16;
    localparam logic [3:0]  RST_AXIS_ENABLE  = 4'hF;
    localparam logic        RST_AUTO_SEND    = 1'b0;
    localparam logic [7:0]  RST_RPT_TAG      = 8'd3;
    localparam logic [31:0] RST_RANGE        = 32'h7FFF_8001;

    // Opcodes carried in s_tuser
    localparam logic [1:0] OP_BUTTON = 2'd0;
    localparam logic [1:0] OP_AXIS   = 2'd1;
    localparam logic [1:0] OP_SEND   = 2'd2;

    // Axis output scaling: -32767 .. 32767
    localparam logic [15:0] AXIS_OUT_MIN  = 16'h8001;
    localparam logic [15:0] AXIS_OUT_OFS  = 16'd32767;
    localparam logic [15:0] AXIS_OUT_SPAN = 16'd65534;

    typedef struct packed {
        logic [5:0]       button_count;
        logic [3:0]       axis_enable;
        logic             auto_send;
        logic [7:0]       rpt_tag;
        logic [3:0][31:0] axis_range;
    } cfg_t;

    typedef struct packed {
        logic update;     // apply accepted input beat to state
        logic start;      // clear report counters
        logic emit_btn;   // load next button byte into output register
        logic load_axis;  // clamp current axis, latch offset and span
        logic next_axis;  // advance axis counter
        logic mul;        // form dividend, reset divider
        logic div_step;   // one restoring divide step
        logic emit_lo;    // load low byte of scaled axis
        logic emit_hi;    // load high byte of scaled axis
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic report_go;  // accepted beat asks for a non-empty report
        logic btn_left;
        logic axis_done;
        logic axis_en;
        logic div_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

`default_nettype wire

@@ design/hjrb_regs.sv @@
// APB configuration registers of the report builder.
// Depends on hjrb_pkg for the register map and reset values.
`timescale 1ns / 1ps
`default_nettype none

module hjrb_regs
    import hjrb_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [HJRB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output cfg_t                        cfg
);

    cfg_t        cfg_reg;
    logic [2:0]  reg_sel;
    logic        wr_en;

    assign reg_sel = paddr[HJRB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.button_count <= RST_BUTTON_COUNT;
            cfg_reg.axis_enable  <= RST_AXIS_ENABLE;
            cfg_reg.auto_send    <= RST_AUTO_SEND;
            cfg_reg.rpt_tag      <= RST_RPT_TAG;
            cfg_reg.axis_range   <= {4{RST_RANGE}};
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_BUTTON_COUNT: cfg_reg.button_count  <= pwdata[5:0];
                REG_AXIS_ENABLE:  cfg_reg.axis_enable   <= pwdata[3:0];
                REG_AUTO_SEND:    cfg_reg.auto_send     <= pwdata[0];
                REG_RPT_TAG:      cfg_reg.rpt_tag       <= pwdata[7:0];
                REG_X_RANGE:      cfg_reg.axis_range[0] <= pwdata;
                REG_Y_RANGE:      cfg_reg.axis_range[1] <= pwdata;
                REG_Z_RANGE:      cfg_reg.axis_range[2] <= pwdata;
                REG_RX_RANGE:     cfg_reg.axis_range[3] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_BUTTON_COUNT: prdata = {26'd0, cfg_reg.button_count};
            REG_AXIS_ENABLE:  prdata = {28'd0, cfg_reg.axis_enable};
            REG_AUTO_SEND:    prdata = {31'd0, cfg_reg.auto_send};
            REG_RPT_TAG:      prdata = {24'd0, cfg_reg.rpt_tag};
            REG_X_RANGE:      prdata = cfg_reg.axis_range[0];
            REG_Y_RANGE:      prdata = cfg_reg.axis_range[1];
            REG_Z_RANGE:      prdata = cfg_reg.axis_range[2];
            REG_RX_RANGE:     prdata = cfg_reg.axis_range[3];
        endcase
    end

endmodule

`default_nettype wire

@@ design/hjrb_ctrl.sv @@
// Sequencer of the report builder: walks button bytes, then each enabled
// axis through clamp, multiply, divide and two byte beats. Uses hjrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hjrb_ctrl
    import hjrb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ctrl_stat_t stat,
    output ctrl_cmd_t       cmd,
    output logic            s_ready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BTN  = 3'd1;
    localparam logic [2:0] ST_AXIS = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_LO   = 3'd5;
    localparam logic [2:0] ST_HI   = 3'd6;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (stat.in_valid) begin
                    cmd.update = 1'b1;
                    if (stat.report_go) begin
                        cmd.start  = 1'b1;
                        state_next = ST_BTN;
                    end
                end
            end
            ST_BTN: begin
                if (!stat.btn_left) begin
                    state_next = ST_AXIS;
                end else if (stat.out_free) begin
                    cmd.emit_btn = 1'b1;
                end
            end
            ST_AXIS: begin
                if (stat.axis_done) begin
                    state_next = ST_IDLE;
                end else if (stat.axis_en) begin
                    cmd.load_axis = 1'b1;
                    state_next    = ST_MUL;
                end else begin
                    cmd.next_axis = 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_LO;
                end
            end
            ST_LO: begin
                if (stat.out_free) begin
                    cmd.emit_lo = 1'b1;
                    state_next  = ST_HI;
                end
            end
            ST_HI: begin
                if (stat.out_free) begin
                    cmd.emit_hi   = 1'b1;
                    cmd.next_axis = 1'b1;
                    state_next    = ST_AXIS;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/hjrb_dp.sv @@
// Datapath of the report builder: button and axis state, axis clamp and
// scale (one multiply, bit-serial divide), output register. Uses hjrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hjrb_dp
    import hjrb_pkg::*;
#(
    parameter int MAX_BUTTONS = HJRB_MAX_BUTTONS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire ctrl_cmd_t   cmd,
    output ctrl_stat_t       stat,
    input  wire logic        s_valid,
    input  wire logic [1:0]  in_opcode,
    input  wire logic [4:0]  in_button_index,
    input  wire logic        in_button_level,
    input  wire logic [1:0]  in_axis_select,
    input  wire logic [15:0] in_axis_sample,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       out_report_byte,
    output logic [3:0]       out_byte_position,
    output logic [7:0]       out_report_tag,
    output logic             out_last_byte
);

    localparam int BtnW = (MAX_BUTTONS < HJRB_BTN_STORE_MAX) ? MAX_BUTTONS
                                                             : HJRB_BTN_STORE_MAX;

    // State
    logic [BtnW-1:0]         button_bits_reg;
    logic [3:0][15:0]        axis_values_reg;

    // Report counters
    logic [3:0]              pos_reg;
    logic [2:0]              btn_cnt_reg;
    logic [2:0]              axis_cnt_reg;

    // Scaling
    logic [15:0]             off_reg;
    logic [15:0]             den_reg;
    logic [15:0]             rem_reg;
    logic [31:0]             quo_reg;
    logic [4:0]              div_cnt_reg;

    // Output register
    logic                    m_valid_reg;
    logic [7:0]              byte_reg;
    logic [3:0]              bpos_reg;
    logic                    last_reg;

    logic [5:0]              n_use;
    logic [2:0]              n_bytes;
    logic [3:0]              rep_len;
    logic [31:0]             btn_vis;
    logic                    idx_ok;
    logic                    want;
    logic                    out_free;
    logic                    emit;
    logic [7:0]              emit_byte;
    logic                    emit_last;

    logic signed [15:0]      r_lo, r_hi, r_min, r_max, v_raw, v_clamp;
    logic                    swap;
    logic [16:0]             off_wide, den_wide;
    logic [16:0]             rem_shift;
    logic                    rem_ge;
    logic [15:0]             scaled;

    assign n_use   = (cfg.button_count > 6'(BtnW)) ? 6'(BtnW) : cfg.button_count;
    assign n_bytes = 3'((n_use + 6'd7) >> 3);
    assign rep_len = 4'(n_bytes)
                   + {2'd0, cfg.axis_enable[0], 1'b0} + {2'd0, cfg.axis_enable[1], 1'b0}
                   + {2'd0, cfg.axis_enable[2], 1'b0} + {2'd0, cfg.axis_enable[3], 1'b0};

    always_comb begin
        btn_vis = '0;
        for (int i = 0; i < BtnW; i++) begin
            btn_vis[i] = button_bits_reg[i] & (6'(i) < n_use);
        end
    end

    assign idx_ok = ({1'b0, in_button_index} < n_use);

    always_comb begin
        unique case (in_opcode)
            OP_BUTTON: want = idx_ok & cfg.auto_send;
            OP_AXIS:   want = cfg.auto_send;
            OP_SEND:   want = 1'b1;
            default:   want = 1'b0;
        endcase
    end

    // Axis clamp; a reversed range inverts the value
    assign r_lo    = $signed(cfg.axis_range[axis_cnt_reg[1:0]][15:0]);
    assign r_hi    = $signed(cfg.axis_range[axis_cnt_reg[1:0]][31:16]);
    assign swap    = (r_lo > r_hi);
    assign r_min   = swap ? r_hi : r_lo;
    assign r_max   = swap ? r_lo : r_hi;
    assign v_raw   = $signed(axis_values_reg[axis_cnt_reg[1:0]]);
    assign v_clamp = (v_raw < r_min) ? r_min : ((v_raw > r_max) ? r_max : v_raw);
    assign off_wide = swap ? ({r_max[15], r_max} - {v_clamp[15], v_clamp})
                           : ({v_clamp[15], v_clamp} - {r_min[15], r_min});
    assign den_wide = {r_max[15], r_max} - {r_min[15], r_min};

    // Restoring divide step
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    assign scaled = (den_reg == 16'd0) ? AXIS_OUT_MIN : (quo_reg[15:0] - AXIS_OUT_OFS);

    assign out_free = !m_valid_reg | m_ready;
    assign emit     = cmd.emit_btn | cmd.emit_lo | cmd.emit_hi;

    always_comb begin
        if (cmd.emit_btn) begin
            emit_byte = btn_vis[{btn_cnt_reg[1:0], 3'b000} +: 8];
        end else if (cmd.emit_lo) begin
            emit_byte = scaled[7:0];
        end else begin
            emit_byte = scaled[15:8];
        end
    end
    assign emit_last = (pos_reg + 4'd1 == rep_len);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_bits_reg <= '0;
            axis_values_reg <= '0;
        end else if (cmd.update) begin
            if (in_opcode == OP_BUTTON && idx_ok) begin
                for (int i = 0; i < BtnW; i++) begin
                    if (in_button_index == 5'(i)) begin
                        button_bits_reg[i] <= in_button_level;
                    end
                end
            end
            if (in_opcode == OP_AXIS) begin
                axis_values_reg[in_axis_select] <= in_axis_sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            btn_cnt_reg  <= '0;
            axis_cnt_reg <= '0;
            div_cnt_reg  <= '0;
        end else begin
            if (cmd.start) begin
                pos_reg      <= '0;
                btn_cnt_reg  <= '0;
                axis_cnt_reg <= '0;
            end
            if (emit) begin
                pos_reg <= pos_reg + 4'd1;
            end
            if (cmd.emit_btn) begin
                btn_cnt_reg <= btn_cnt_reg + 3'd1;
            end
            if (cmd.next_axis) begin
                axis_cnt_reg <= axis_cnt_reg + 3'd1;
            end
            if (cmd.mul) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_axis) begin
            off_reg <= off_wide[15:0];
            den_reg <= den_wide[15:0];
        end
        if (cmd.mul) begin
            quo_reg <= off_reg * AXIS_OUT_SPAN;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? 16'(rem_shift - {1'b0, den_reg}) : rem_shift[15:0];
            quo_reg <= {quo_reg[30:0], rem_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg <= emit_byte;
            bpos_reg <= pos_reg;
            last_reg <= emit_last;
        end
    end

    assign stat.in_valid  = s_valid;
    assign stat.report_go = want & (rep_len != 4'd0);
    assign stat.btn_left  = (btn_cnt_reg < n_bytes);
    assign stat.axis_done = axis_cnt_reg[2];
    assign stat.axis_en   = cfg.axis_enable[axis_cnt_reg[1:0]];
    assign stat.div_last  = (div_cnt_reg == 5'd31);
    assign stat.out_free  = out_free;

    assign m_valid           = m_valid_reg;
    assign out_report_byte   = byte_reg;
    assign out_byte_position = bpos_reg;
    assign out_report_tag    = cfg.rpt_tag;
    assign out_last_byte     = last_reg;

endmodule

`default_nettype wire

@@ design/hid_joystick_report_builder_top.sv @@
// Top level of the HID joystick report builder.
// Instantiates hjrb_regs, hjrb_ctrl and hjrb_dp; types from hjrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps button bits and four signed axis values and, on a send
// beat or (with auto_send) after any accepted update, streams the HID input
// report out one byte per beat: the button bytes first, then two bytes per
// enabled axis in X, Y, Z, Rx order, low byte first. Each axis is clamped to
// its range, inverted when the range is given reversed and scaled onto
// -32767..32767 by truncating division; an empty range sends -32767.
// Rate: one input beat is taken at a time; s_tready is high only while the
// sequencer is idle. A report walks the button bytes, then each axis: a
// disabled axis is skipped, an enabled one goes through clamp, multiply,
// 32-step bit-serial divide and two byte beats, then the sequencer goes
// back to idle. Backpressure on m_tready only stretches a report.
// The last byte of a report waits in the output register while the next
// input beat is already accepted. report_tag follows the tag register live;
// the tag register is to be written only while idle, which the block itself
// does not enforce. No reset sweep is needed.
module hid_joystick_report_builder_top
    import hjrb_pkg::*;
#(
    parameter int MAX_BUTTONS = HJRB_MAX_BUTTONS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // APB configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [HJRB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready,
    // Input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [4:0] button_index, [5] button_level, [7:6] axis_select,
    // [23:8] axis_sample
    input  wire logic [23:0]            s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]             s_tuser,
    // Report byte stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [7:0] report_byte, [11:8] byte_position, [19:12] report_tag,
    // [23:20] zero
    output logic [23:0]                 m_tdata,
    output logic                        m_tlast
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    logic       s_ready;
    logic [7:0] rep_byte;
    logic [3:0] rep_pos;
    logic [7:0] rep_tag;

    assign pready = 1'b1;

    hjrb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    hjrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    // Input beat fields go straight to the datapath; only the update cycle
    // (IDLE with s_tvalid) consumes them.
    hjrb_dp #(
        .MAX_BUTTONS (MAX_BUTTONS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .cmd               (cmd),
        .stat              (stat),
        .s_valid           (s_tvalid),
        .in_opcode         (s_tuser),
        .in_button_index   (s_tdata[4:0]),
        .in_button_level   (s_tdata[5]),
        .in_axis_select    (s_tdata[7:6]),
        .in_axis_sample    (s_tdata[23:8]),
        .m_valid           (m_tvalid),
        .m_ready           (m_tready),
        .out_report_byte   (rep_byte),
        .out_byte_position (rep_pos),
        .out_report_tag    (rep_tag),
        .out_last_byte     (m_tlast)
    );

    assign s_tready = s_ready;
    assign m_tdata  = {4'd0, rep_tag, rep_pos, rep_byte};

endmodule

`default_nettype wire

@@ design/hjrb_checker.sv @@
// Port-level checks for the report builder, bound to the top level.
// Depends on hjrb_pkg and hid_joystick_report_builder_top.
`timescale 1ns / 1ps
`default_nettype none

module hjrb_checker
    import hjrb_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    // Sync reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled report beat changed");

    // Report is at most 12 bytes.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:8] <= 4'd11)
        else $error("byte_position beyond report length");

    a_pos_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11:8] == 4'd11 |-> m_tlast)
        else $error("twelfth byte not marked last");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:20] == 4'd0)
        else $error("tdata padding not zero");

endmodule

bind hid_joystick_report_builder_top hjrb_checker u_hjrb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/hid_joystick_report_builder_top_tb.sv @@
// Self-checking testbench for hid_joystick_report_builder_top.
// Predicts every report byte from button/axis beats and APB settings;
// needs hjrb_pkg and the design files only.
`timescale 1ns / 1ps

module hid_joystick_report_builder_top_tb;
    import hjrb_pkg::*;

    localparam int  BTN_LIMIT     = HJRB_MAX_BUTTONS_DEF;
    localparam int  SCALED_MIN    = -32767;
    localparam int  SCALED_SPAN   = 65534;
    localparam int  SETTLE_CYCLES = 200;     // longer than the worst-case report
    localparam int  CYCLE_LIMIT   = 1000000;
    localparam int  PHASE_BEATS   = 68;
    localparam int  NUM_PHASES    = 6;
    localparam int  MAX_SHOWN     = 10;
    localparam logic [1:0] OP_IDLE = 2'd3;   // unused opcode, no effect

    typedef struct {
        logic [1:0]  op;
        logic [4:0]  btn_idx;
        logic        btn_lvl;
        logic [1:0]  axis_sel;
        logic [15:0] sample;
        bit          wait_drain;  // hold this beat until all reports are out
    } joy_cmd_t;

    typedef struct {
        logic [7:0] data;
        logic [3:0] pos;
        logic [7:0] tag;
        logic       last;
    } report_beat_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [HJRB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    hid_joystick_report_builder_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Shadow of the block: settings, buttons, raw axis values
    cfg_t               cfg_model;
    logic [31:0]        btn_state;
    logic signed [15:0] axis_state [4];

    joy_cmd_t     cmd_queue [$];
    report_beat_t report_bytes_due [$];

    int  beats_issued = 0;
    int  beats_taken  = 0;
    int  fail_cnt     = 0;
    int  cycle_cnt    = 0;
    bit  feed_on      = 1'b0;
    bit  sender_idle_on   = 1'b0;
    bit  receiver_stall_on = 1'b0;
    bit  cmd_fire     = 1'b0;
    int  gap_left     = 0;
    int  stall_left   = 0;

    // ---------------------------------------------------------------- predictor

    function automatic int buttons_in_use();
        int n;
        n = cfg_model.button_count;
        if (n > BTN_LIMIT) n = BTN_LIMIT;
        if (n > 32) n = 32;
        return n;
    endfunction

    function automatic logic [15:0] scale_axis(input logic signed [15:0] raw,
                                               input logic [31:0] rng);
        int     lo, hi, rmin, rmax, v, outv;
        longint num;
        lo   = $signed(rng[15:0]);
        hi   = $signed(rng[31:16]);
        rmin = (lo < hi) ? lo : hi;
        rmax = (lo < hi) ? hi : lo;
        v    = raw;
        if (v < rmin) v = rmin;
        if (v > rmax) v = rmax;
        if (lo > hi) v = rmax - v + rmin;     // reversed range flips the axis
        if (rmax == rmin) begin
            outv = SCALED_MIN;
        end else begin
            num  = longint'(v - rmin) * longint'(SCALED_SPAN);
            outv = int'(num / longint'(rmax - rmin)) + SCALED_MIN;
        end
        return outv[15:0];
    endfunction

    function automatic void emit_report();
        logic [7:0]   bytes [$];
        logic [31:0]  shown;
        logic [15:0]  w;
        int           n;
        report_beat_t b;
        n = buttons_in_use();
        // bits at or above the count are kept but sent as zero
        shown = (n >= 32) ? btn_state : (btn_state & ((32'd1 << n) - 32'd1));
        for (int k = 0; k < (n + 7) / 8; k++)
            bytes.push_back(shown[8*k +: 8]);
        for (int a = 0; a < 4; a++) begin
            if (cfg_model.axis_enable[a]) begin
                w = scale_axis(axis_state[a], cfg_model.axis_range[a]);
                bytes.push_back(w[7:0]);
                bytes.push_back(w[15:8]);
            end
        end
        for (int i = 0; i < bytes.size(); i++) begin
            b.data = bytes[i];
            b.pos  = 4'(i);
            b.tag  = cfg_model.rpt_tag;
            b.last = (i == bytes.size() - 1);
            report_bytes_due.push_back(b);
        end
    endfunction

    function automatic void apply_command(input logic [1:0] op, input logic [4:0] idx,
                                          input logic lvl, input logic [1:0] sel,
                                          input logic [15:0] sample);
        case (op)
            OP_BUTTON: begin
                if (int'(idx) < buttons_in_use()) begin
                    btn_state[idx] = lvl;
                    if (cfg_model.auto_send) emit_report();
                end
            end
            OP_AXIS: begin
                axis_state[sel] = sample;
                if (cfg_model.auto_send) emit_report();
            end
            OP_SEND: emit_report();
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h7FFF;
        if (r < 20) return 16'h8000;
        if (r < 25) return 16'h0000;
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] rand_range();
        logic [15:0] h;
        h = 16'($urandom);
        case ($urandom_range(0, 5))
            0:       return RST_RANGE;
            1:       return 32'h7FFF_8000;   // full signed span
            2:       return 32'h8000_7FFF;   // full span, reversed
            3:       return {h, h};          // empty range
            4:       return {16'h0040, 16'hFFC0};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_cmd(input logic [1:0] op, input logic [4:0] idx,
                             input logic lvl, input logic [1:0] sel,
                             input logic [15:0] sample, input bit hold);
        joy_cmd_t c;
        c.op = op;  c.btn_idx = idx;  c.btn_lvl = lvl;
        c.axis_sel = sel;  c.sample = sample;  c.wait_drain = hold;
        cmd_queue.push_back(c);
        beats_issued++;
    endtask

    task automatic queue_random_cmd(input bit hold);
        int         r, n;
        logic [1:0] op;
        logic [4:0] idx;
        r = $urandom_range(0, 99);
        n = buttons_in_use();
        if (r < 38)      op = OP_BUTTON;
        else if (r < 76) op = OP_AXIS;
        else if (r < 94) op = OP_SEND;
        else             op = OP_IDLE;
        // mostly valid button numbers; some land past the count
        if (n > 0 && $urandom_range(0, 9) != 0) idx = 5'($urandom_range(0, n - 1));
        else                                    idx = 5'($urandom);
        queue_cmd(op, idx, 1'($urandom), 2'($urandom), rand_sample(), hold);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BUTTON_COUNT: cfg_model.button_count = val[5:0];
            REG_AXIS_ENABLE:  cfg_model.axis_enable  = val[3:0];
            REG_AUTO_SEND:    cfg_model.auto_send    = val[0];
            REG_RPT_TAG:      cfg_model.rpt_tag      = val[7:0];
            default:          cfg_model.axis_range[idx - REG_X_RANGE] = val;
        endcase
    endtask

    task automatic write_ranges(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input logic [31:0] rx);
        write_reg(REG_X_RANGE, x);
        write_reg(REG_Y_RANGE, y);
        write_reg(REG_Z_RANGE, z);
        write_reg(REG_RX_RANGE, rx);
    endtask

    // All beats taken, all report bytes seen, then let the sequencer go idle.
    task automatic drain_and_settle();
        while (beats_taken != beats_issued || report_bytes_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge aclk) begin
        joy_cmd_t cur;
        if (feed_on && (!s_tvalid || cmd_fire)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0 &&
                         !(cmd_queue[0].wait_drain && report_bytes_due.size() != 0)) begin
                cur = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur.op;
                s_tdata  <= {cur.sample, cur.axis_sel, cur.btn_lvl, cur.btn_idx};
                if (sender_idle_on && $urandom_range(0, 2) != 0) gap_left = pick_pause();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side backpressure
    always @(negedge aclk) begin
        if (!feed_on) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (receiver_stall_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_pause() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin
        report_beat_t want;
        if (!aresetn) begin
            cmd_fire <= 1'b0;
        end else begin
            cmd_fire <= s_tvalid && s_tready;
            // check outputs before predicting this edge's input beat
            if (m_tvalid && m_tready) begin
                if (report_bytes_due.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_SHOWN)
                        $display("%0t: unexpected report beat data=%h pos=%0d tag=%h last=%b",
                                 $realtime, m_tdata[7:0], m_tdata[11:8], m_tdata[19:12],
                                 m_tlast);
                end else begin
                    want = report_bytes_due.pop_front();
                    if (m_tdata[7:0] !== want.data || m_tdata[11:8] !== want.pos ||
                        m_tdata[19:12] !== want.tag || m_tlast !== want.last) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_SHOWN)
                            $display("%0t: mismatch exp %h/%0d/%h/%b act %h/%0d/%h/%b",
                                     $realtime, want.data, want.pos, want.tag, want.last,
                                     m_tdata[7:0], m_tdata[11:8], m_tdata[19:12], m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                beats_taken++;
                apply_command(s_tuser, s_tdata[4:0], s_tdata[5], s_tdata[7:6],
                              s_tdata[23:8]);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        cfg_model.button_count = RST_BUTTON_COUNT;
        cfg_model.axis_enable  = RST_AXIS_ENABLE;
        cfg_model.auto_send    = RST_AUTO_SEND;
        cfg_model.rpt_tag      = RST_RPT_TAG;
        for (int a = 0; a < 4; a++) begin
            cfg_model.axis_range[a] = RST_RANGE;
            axis_state[a] = '0;
        end
        btn_state = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        feed_on = 1'b1;

        // Reset settings: 16 buttons, all axes, default ranges
        queue_cmd(OP_SEND,   5'd0,  1'b0, 2'd0, 16'h0000, 1'b0);
        queue_cmd(OP_BUTTON, 5'd0,  1'b1, 2'd0, 16'h0000, 1'b0);
        queue_cmd(OP_BUTTON, 5'd15, 1'b1, 2'd0, 16'h0000, 1'b0);
        queue_cmd(OP_BUTTON, 5'd16, 1'b1, 2'd0, 16'h0000, 1'b0);  // past count
        queue_cmd(OP_BUTTON, 5'd31, 1'b1, 2'd3, 16'hFFFF, 1'b0);  // past count
        queue_cmd(OP_AXIS,   5'd0,  1'b0, 2'd0, 16'h7FFF, 1'b0);
        queue_cmd(OP_AXIS,   5'd0,  1'b0, 2'd1, 16'h8000, 1'b0);  // below range
        queue_cmd(OP_AXIS,   5'd0,  1'b0, 2'd2, 16'hFFFF, 1'b0);
        queue_cmd(OP_AXIS,   5'd0,  1'b0, 2'd3, 16'h0001, 1'b0);
        queue_cmd(OP_SEND,   5'd0,  1'b0, 2'd0, 16'h0000, 1'b0);
        queue_cmd(OP_IDLE,   5'd31, 1'b1, 2'd3, 16'hFFFF, 1'b0);
        queue_cmd(OP_BUTTON, 5'd0,  1'b0, 2'd0, 16'h0000, 1'b0);
        queue_cmd(OP_SEND,   5'd31, 1'b1, 2'd3, 16'hFFFF, 1'b0);
        drain_and_settle();

        // No buttons, no axes: empty report, every button ignored
        write_reg(REG_BUTTON_COUNT, 32'd0);
        write_reg(REG_AXIS_ENABLE, 32'd0);
        queue_cmd(OP_SEND,   5'd0, 1'b0, 2'd0, 16'h0000, 1'b0);
        queue_cmd(OP_BUTTON, 5'd0, 1'b1, 2'd0, 16'h0000, 1'b0);
        queue_cmd(OP_IDLE,   5'd0, 1'b0, 2'd0, 16'h0000, 1'b0);
        drain_and_settle();

        // Oversized count, auto-send, odd ranges: empty, reversed, full, narrow
        write_reg(REG_BUTTON_COUNT, 32'd63);
        write_reg(REG_AXIS_ENABLE, 32'hF);
        write_reg(REG_AUTO_SEND, 32'd1);
        write_reg(REG_RPT_TAG, 32'hFF);
        write_ranges(32'h1234_1234, 32'h8000_7FFF, 32'h7FFF_8000, 32'h0100_FF00);
        queue_cmd(OP_BUTTON, 5'd31, 1'b1, 2'd0, 16'h0000, 1'b0);
        queue_cmd(OP_AXIS,   5'd0,  1'b0, 2'd0, 16'h0ABC, 1'b0);
        queue_cmd(OP_AXIS,   5'd0,  1'b0, 2'd1, 16'h7FFF, 1'b0);
        queue_cmd(OP_AXIS,   5'd0,  1'b0, 2'd2, 16'h8000, 1'b0);
        queue_cmd(OP_AXIS,   5'd0,  1'b0, 2'd3, 16'h0200, 1'b0);  // above range
        queue_cmd(OP_IDLE,   5'd5,  1'b1, 2'd1, 16'h1111, 1'b0);
        drain_and_settle();

        // Nine buttons: upper bits of second byte are padding
        write_reg(REG_BUTTON_COUNT, 32'd9);
        write_reg(REG_AUTO_SEND, 32'd0);
        queue_cmd(OP_BUTTON, 5'd8, 1'b1, 2'd0, 16'h0000, 1'b0);
        queue_cmd(OP_SEND,   5'd0, 1'b0, 2'd0, 16'h0000, 1'b0);
        drain_and_settle();

        // Random phases, each with its own settings and idling mix
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin write_reg(REG_BUTTON_COUNT, 32'd32); write_reg(REG_AXIS_ENABLE, 32'hF);
                         write_reg(REG_AUTO_SEND, 32'd0);     write_reg(REG_RPT_TAG, 32'h00); end
                1: begin write_reg(REG_BUTTON_COUNT, 32'd1);  write_reg(REG_AXIS_ENABLE, 32'h0);
                         write_reg(REG_AUTO_SEND, 32'd1);     write_reg(REG_RPT_TAG, 32'hFF); end
                2: begin write_reg(REG_BUTTON_COUNT, 32'd17); write_reg(REG_AXIS_ENABLE, 32'h5);
                         write_reg(REG_AUTO_SEND, 32'd0);     write_reg(REG_RPT_TAG, $urandom); end
                3: begin write_reg(REG_BUTTON_COUNT, 32'd0);  write_reg(REG_AXIS_ENABLE, 32'hA);
                         write_reg(REG_AUTO_SEND, 32'd1);     write_reg(REG_RPT_TAG, $urandom); end
                4: begin write_reg(REG_BUTTON_COUNT, 32'd40); write_reg(REG_AXIS_ENABLE, $urandom);
                         write_reg(REG_AUTO_SEND, 32'd1);     write_reg(REG_RPT_TAG, $urandom); end
                default: begin
                         write_reg(REG_BUTTON_COUNT, 32'd24); write_reg(REG_AXIS_ENABLE, 32'hF);
                         write_reg(REG_AUTO_SEND, 32'd0);     write_reg(REG_RPT_TAG, $urandom); end
            endcase
            write_ranges(rand_range(), rand_range(), rand_range(), rand_range());
            sender_idle_on    = (p != 0) && (p != 4);
            receiver_stall_on = (p != 0);
            for (int i = 0; i < PHASE_BEATS; i++)
                queue_random_cmd(i == PHASE_BEATS / 2);
            drain_and_settle();
        end

        if (fail_cnt == 0 && report_bytes_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
